/* rtl/thw_pkg.sv */
package thw_pkg;

	localparam int unsigned THW_NUM_TASKS = 4;
	localparam int unsigned TASK_ID_W     = 3;
	localparam int unsigned MASK_W        = 4;
	localparam int unsigned TIME_W        = 32;
	localparam int unsigned TIMEOUT_W     = 16;
	localparam int unsigned WINDOW_W      = 24;
	localparam int unsigned RELOAD_W      = 12;
	localparam int unsigned APB_DATA_W    = 32;
	localparam int unsigned APB_ADDR_W    = 4;

	localparam int unsigned LSI_HZ     = 40000;
	localparam int unsigned PRESCALE   = 256;
	localparam int unsigned MS_PER_S   = 1000;
	localparam int unsigned RELOAD_MAX = 4095;
	localparam int unsigned RELOAD_MIN = 1;

	// LSI_HZ / (PRESCALE * MS_PER_S) reduces to 5/32, so the reload is (t*5) >> 5
	localparam int unsigned RELOAD_DEN   = PRESCALE * MS_PER_S;
	localparam int unsigned RELOAD_SHIFT = 5;
	localparam int unsigned RELOAD_MUL   = LSI_HZ * (2 ** RELOAD_SHIFT) / RELOAD_DEN;
	localparam int unsigned PROD_W       = TIMEOUT_W + 3;
	localparam int unsigned QUOT_W       = PROD_W - RELOAD_SHIFT;

	localparam int unsigned DEFAULT_TIMEOUT_MS = 1000;
	localparam int unsigned DEFAULT_GRACE_MS   = 30000;
	localparam int unsigned DEFAULT_SILENCE_MS = 30000;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_BEAT  = 2'd1,
		MODE_CHECK = 2'd2,
		MODE_START = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_TIMEOUT = 2'd0,
		REG_GRACE   = 2'd1,
		REG_SILENCE = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [TIMEOUT_W-1:0] wdog_timeout;
		logic [WINDOW_W-1:0]  grace_ms;
		logic [WINDOW_W-1:0]  silence_limit_ms;
	} cfg_t;

	typedef struct packed {
		mode_t                mode;
		logic [TASK_ID_W-1:0] task_id;
	} item_t;

	typedef struct packed {
		logic                tasks_ok;
		logic [MASK_W-1:0]   alive_mask;
		logic [RELOAD_W-1:0] reload;
	} result_t;

	function automatic logic [RELOAD_W-1:0] calc_reload(input logic [TIMEOUT_W-1:0] t);
		logic [PROD_W-1:0] prod;
		logic [QUOT_W-1:0] quot;
		prod = PROD_W'(t) * PROD_W'(RELOAD_MUL);
		quot = prod[PROD_W-1:RELOAD_SHIFT];
		if (quot > QUOT_W'(RELOAD_MAX)) begin
			return RELOAD_W'(RELOAD_MAX);
		end else if (quot < QUOT_W'(RELOAD_MIN)) begin
			return RELOAD_W'(RELOAD_MIN);
		end else begin
			return quot[RELOAD_W-1:0];
		end
	endfunction

endpackage

/* rtl/thw_cfg.sv */
module thw_cfg
	import thw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output cfg_t                  cfg
);

	cfg_t             cfg_q;
	logic             wr_en;
	logic [1:0]       idx;

	assign wr_en = psel && penable && pwrite;
	assign idx   = paddr[APB_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wdog_timeout     <= TIMEOUT_W'(DEFAULT_TIMEOUT_MS);
			cfg_q.grace_ms         <= WINDOW_W'(DEFAULT_GRACE_MS);
			cfg_q.silence_limit_ms <= WINDOW_W'(DEFAULT_SILENCE_MS);
		end else if (wr_en) begin
			unique case (idx)
				REG_TIMEOUT: cfg_q.wdog_timeout     <= pwdata[TIMEOUT_W-1:0];
				REG_GRACE:   cfg_q.grace_ms         <= pwdata[WINDOW_W-1:0];
				REG_SILENCE: cfg_q.silence_limit_ms <= pwdata[WINDOW_W-1:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TIMEOUT: prdata = APB_DATA_W'(cfg_q.wdog_timeout);
			REG_GRACE:   prdata = APB_DATA_W'(cfg_q.grace_ms);
			REG_SILENCE: prdata = APB_DATA_W'(cfg_q.silence_limit_ms);
			default:     prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

/* rtl/thw_core.sv */
module thw_core
	import thw_pkg::*;
#(
	parameter int unsigned NUM_TASKS = THW_NUM_TASKS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] beat_q [NUM_TASKS];
	logic [NUM_TASKS-1:0] alive_q;

	logic [NUM_TASKS-1:0] hit;
	logic [NUM_TASKS-1:0] stale;
	logic [NUM_TASKS-1:0] alive_next;
	logic [TIME_W-1:0]    since_start;
	logic                 in_grace;
	logic                 is_beat;
	logic                 is_check;

	assign is_beat     = (item.mode == MODE_BEAT);
	assign is_check    = (item.mode == MODE_CHECK);
	assign since_start = now_q - start_q;
	assign in_grace    = since_start < TIME_W'(cfg.grace_ms);

	// one subtract and compare per task, all in parallel
	always_comb begin
		for (int i = 0; i < NUM_TASKS; i++) begin
			hit[i]   = (item.task_id == TASK_ID_W'(i));
			stale[i] = (now_q - beat_q[i]) > TIME_W'(cfg.silence_limit_ms);
		end
	end

	always_comb begin
		alive_next = alive_q;
		if (is_beat) begin
			alive_next = alive_q | hit;
		end else if (is_check && !in_grace) begin
			alive_next = alive_q & ~stale;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q   <= '0;
			start_q <= '0;
			alive_q <= '0;
			for (int i = 0; i < NUM_TASKS; i++) begin
				beat_q[i] <= '0;
			end
		end else if (fire) begin
			alive_q <= alive_next;
			unique case (item.mode)
				MODE_TICK:  now_q   <= now_q + TIME_W'(1);
				MODE_START: start_q <= now_q;
				MODE_BEAT: begin
					for (int i = 0; i < NUM_TASKS; i++) begin
						if (hit[i]) begin
							beat_q[i] <= now_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	for (genvar g = 0; g < MASK_W; g++) begin : g_mask
		if (g < NUM_TASKS) begin : g_live
			assign result.alive_mask[g] = alive_next[g];
		end else begin : g_none
			assign result.alive_mask[g] = 1'b0;
		end
	end

	assign result.tasks_ok = is_check && (in_grace || !(|stale));
	assign result.reload   = (item.mode == MODE_START) ? calc_reload(cfg.wdog_timeout) : '0;

endmodule

/* rtl/task_heartbeat_watchdog.sv */
// Task heartbeat watchdog.
// Request channel (req_valid/req_ready) carries one beat per item: mode picks
// tick (advance the millisecond counter), heartbeat (stamp task_id and mark it
// alive), check (compare every task's silence against the limit) or start
// (record the start time and return the watchdog reload value).
// Response channel (rsp_valid/rsp_ready) returns exactly one beat per request:
// tasks_ok, the alive mask after the item, and the reload value.
// Path: the input register takes an accepted beat, and the result register
// takes it from there once that register is free or being emptied.
// Throughput: one item per cycle while rsp_ready stays high; the check runs
// one subtract-and-compare per task side by side, so nothing iterates.
// Stall: when the receiver holds rsp_ready low the result register holds and
// the input register takes at most one more beat before req_ready drops.
// Reset (arst_n low): clear counter, start time, last-beat stamps and alive
// flags; registers return to 1000 / 30000 / 30000 ms. No clearing pass.
// Configuration via APB at byte addresses 0, 4, 8; write only while idle.
module task_heartbeat_watchdog
	import thw_pkg::*;
#(
	parameter int unsigned NUM_TASKS = THW_NUM_TASKS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic [1:0]            mode,
	input  logic [TASK_ID_W-1:0]  task_id,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic                  tasks_ok,
	output logic [MASK_W-1:0]     alive_mask,
	output logic [RELOAD_W-1:0]   reload
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t result;
	result_t result_q;
	logic    rsp_valid_q;

	assign pready = 1'b1;

	thw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// move the held item into the result register when that register is free
	// or being emptied this cycle
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	// input register: payload only, no reset needed
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1.mode    <= mode_t'(mode);
			item_s1.task_id <= task_id;
		end
	end

	thw_core #(
		.NUM_TASKS (NUM_TASKS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result register: hold while the receiver stalls
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign tasks_ok   = result_q.tasks_ok;
	assign alive_mask = result_q.alive_mask;
	assign reload     = result_q.reload;

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid_q)
		else $error("advanced item did not reach the result register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && rsp_valid_q && !rsp_ready) |-> !req_ready)
		else $error("input register open while its item is stalled");

	a_start_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.mode == MODE_START) |=> (result_q.reload != '0))
		else $error("start item returned a zero reload");

	a_health_only_check: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.mode != MODE_CHECK) |=> !result_q.tasks_ok)
		else $error("healthy flag raised on a non-check item");

endmodule
